FILE: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes,
// status codes, state types and the front-to-back job word. No dependencies.
`default_nettype none
package rau_pkg;
    localparam int OperandBits = 16;
    localparam int MagBits     = 2 * OperandBits + 1;   // cross-product sum magnitude
    localparam int NumBits     = 33;
    localparam int DenBits     = 31;
    localparam int CntBits     = $clog2(MagBits + 1);
    localparam int QDepth      = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_ZERODEN = 2'd2
    } t_status;

    // job kinds handed to the back end
    typedef enum logic [1:0] {
        JK_ARITH = 2'd0,   // reduce one fraction
        JK_EQ    = 2'd1,   // reduce two fractions and compare
        JK_FIXED = 2'd2    // result known at once
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [1:0]           status;
        logic                 neg_a;
        logic [MagBits-1:0]   num_a;
        logic [MagBits-1:0]   den_a;
        logic                 neg_b;
        logic [MagBits-1:0]   num_b;
        logic [MagBits-1:0]   den_b;
    } t_job;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GCD,
        BS_DIVN,
        BS_DIVD,
        BS_NEXT,
        BS_OUT
    } t_bstate;
endpackage
`default_nettype wire

FILE: rtl/rau_front.sv
// Front end: accepts operand words, classifies them and forms the
// cross products (registered) before pushing a job. Uses rau_pkg.
`default_nettype none
module rau_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  [2:0]              i_req_type,
    input  wire  [15:0]             i_a_num,
    input  wire  [15:0]             i_a_den,
    input  wire  [15:0]             i_b_num,
    input  wire  [15:0]             i_b_den,
    output logic                    o_job_valid,
    input  wire                     i_job_full,
    output rau_pkg::t_job           o_job
);
    localparam int W = rau_pkg::OperandBits;
    localparam int M = rau_pkg::MagBits;

    // stage 1: sign/magnitude operands
    logic         r_v1, n_v1;
    logic [2:0]   r_op;
    logic         r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    // stage 2: products
    logic         r_v2;
    rau_pkg::t_job r_job, n_job;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    wire adv2 = !r_v2 || !i_job_full;
    assign n_v1 = r_v1 && !adv2 ? 1'b1 : (i_valid && !o_stall);
    assign o_stall = r_v1 && !adv2;
    wire acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        if (acc) begin
            r_op   <= i_req_type;
            r_an   <= mag_of(i_a_num[W-1:0]);
            r_ad   <= mag_of(i_a_den[W-1:0]);
            r_bn   <= mag_of(i_b_num[W-1:0]);
            r_bd   <= mag_of(i_b_den[W-1:0]);
            r_an_s <= i_a_num[W-1];
            r_ad_s <= i_a_den[W-1];
            r_bn_s <= i_b_num[W-1];
            r_bd_s <= i_b_den[W-1];
        end
    end

    logic [2*W-1:0] p_anbd, p_bnad, p_anbn, p_adbd, p_adbn;
    logic [M-1:0]   sum_mag;
    logic           sgn1, sgn2, sum_neg, z1, z2;
    always_comb begin
        p_anbd = r_an * r_bd;
        p_bnad = r_bn * r_ad;
        p_anbn = r_an * r_bn;
        p_adbd = r_ad * r_bd;
        p_adbn = r_ad * r_bn;
        z1 = (p_anbd == '0);
        z2 = (p_bnad == '0);
        sgn1 = !z1 && (r_an_s ^ r_bd_s);
        sgn2 = !z2 && (r_bn_s ^ r_ad_s ^ (r_op == rau_pkg::OP_SUB));
        if (sgn1 == sgn2) begin
            sum_mag = {1'b0, p_anbd} + {1'b0, p_bnad};
            sum_neg = sgn1;
        end else if (p_anbd >= p_bnad) begin
            sum_mag = {1'b0, p_anbd - p_bnad};
            sum_neg = sgn1;
        end else begin
            sum_mag = {1'b0, p_bnad - p_anbd};
            sum_neg = sgn2;
        end
        n_job = '0;
        n_job.kind   = rau_pkg::JK_ARITH;
        n_job.status = rau_pkg::ST_OK;
        // denominators' signs folded into the numerator sign
        unique case (r_op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                n_job.num_a = sum_mag;
                n_job.neg_a = sum_neg ^ r_ad_s ^ r_bd_s;
                n_job.den_a = {1'b0, p_adbd};
            end
            rau_pkg::OP_MUL: begin
                n_job.num_a = {1'b0, p_anbn};
                n_job.neg_a = r_an_s ^ r_bn_s ^ r_ad_s ^ r_bd_s;
                n_job.den_a = {1'b0, p_adbd};
            end
            rau_pkg::OP_DIV: begin
                n_job.num_a = {1'b0, p_anbd};
                n_job.neg_a = r_an_s ^ r_bd_s ^ r_ad_s ^ r_bn_s;
                n_job.den_a = {1'b0, p_adbn};
                if (r_bn == '0) begin
                    n_job.kind   = rau_pkg::JK_FIXED;
                    n_job.status = rau_pkg::ST_DIV0;
                end
            end
            rau_pkg::OP_EQ: begin
                n_job.kind  = rau_pkg::JK_EQ;
                n_job.num_a = M'(r_an);
                n_job.den_a = M'(r_ad);
                n_job.neg_a = r_an_s ^ r_ad_s;
                n_job.num_b = M'(r_bn);
                n_job.den_b = M'(r_bd);
                n_job.neg_b = r_bn_s ^ r_bd_s;
            end
            default: n_job.kind = rau_pkg::JK_FIXED;
        endcase
        if (r_op <= rau_pkg::OP_EQ && (r_ad == '0 || r_bd == '0)) begin
            n_job.kind   = rau_pkg::JK_FIXED;
            n_job.status = rau_pkg::ST_ZERODEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2 && r_v1) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_v2;
    assign o_job       = r_job;
endmodule
`default_nettype wire

FILE: rtl/rau_queue.sv
// Short job queue between front and back ends. Uses rau_pkg.
`default_nettype none
module rau_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  rau_pkg::t_job  i_job,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_empty,
    output rau_pkg::t_job  o_job
);
    localparam int D = rau_pkg::QDepth;
    localparam int A = $clog2(D);
    rau_pkg::t_job r_mem [D];
    logic [A-1:0] r_wp, r_rp;
    logic [A:0]   r_cnt;

    assign o_full  = (r_cnt == (A+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    wire do_push = i_push && !o_full;
    wire do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (A+1)'(do_push) - (A+1)'(do_pop);
        end
        if (do_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

FILE: rtl/rau_back.sv
// Back end: Euclidean GCD with a bit-serial remainder unit, then exact
// division of numerator and denominator by the GCD. Uses rau_pkg.
`default_nettype none
module rau_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    input  rau_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [rau_pkg::NumBits-1:0] o_res_num,
    output logic [rau_pkg::DenBits-1:0]  o_res_den,
    output logic [1:0]                   o_status,
    output logic                         o_is_equal
);
    localparam int M = rau_pkg::MagBits;
    localparam int C = rau_pkg::CntBits;

    rau_pkg::t_bstate r_st, n_st;
    rau_pkg::t_job    r_job;
    logic         r_second;                 // working on fraction b (equality)
    logic [M-1:0] r_x, r_y;                 // gcd pair
    logic [M-1:0] r_rem, r_quo, r_dvd;      // serial divider
    logic [C-1:0] r_bit;
    logic         r_divbusy;
    logic [M-1:0] r_g, r_qn, r_qd;
    logic         r_neg;
    logic [M-1:0] r_ran, r_rad;             // fraction a reduced
    logic         r_rneg;

    // one restoring step
    logic [M:0]   trial;
    logic [M-1:0] rsh;
    logic [M-1:0] dsr;
    always_comb begin
        dsr   = (r_st == rau_pkg::BS_GCD) ? r_y : r_g;
        rsh   = {r_rem[M-2:0], r_dvd[M-1]};
        trial = {r_rem, r_dvd[M-1]} - {1'b0, dsr};
    end

    wire last = (r_bit == '0);
    wire cur_num_zero = r_second ? (r_job.num_b == '0) : (r_job.num_a == '0);

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            rau_pkg::BS_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                n_st  = rau_pkg::BS_NEXT;
            end
            rau_pkg::BS_NEXT: begin
                if (r_job.kind == rau_pkg::JK_FIXED || cur_num_zero) n_st = rau_pkg::BS_OUT;
                else n_st = rau_pkg::BS_GCD;
                if (r_job.kind == rau_pkg::JK_EQ && !r_second && cur_num_zero)
                    n_st = rau_pkg::BS_NEXT;
            end
            rau_pkg::BS_GCD:  if (!r_divbusy && r_y == '0) n_st = rau_pkg::BS_DIVN;
            rau_pkg::BS_DIVN: if (r_divbusy && last) n_st = rau_pkg::BS_DIVD;
            rau_pkg::BS_DIVD: if (r_divbusy && last) begin
                n_st = (r_job.kind == rau_pkg::JK_EQ && !r_second)
                       ? rau_pkg::BS_NEXT : rau_pkg::BS_OUT;
            end
            rau_pkg::BS_OUT:  if (!i_stall) n_st = rau_pkg::BS_IDLE;
            default: n_st = rau_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rau_pkg::BS_IDLE;
            r_divbusy <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                rau_pkg::BS_IDLE: begin
                    r_second <= 1'b0;
                    r_divbusy <= 1'b0;
                end
                rau_pkg::BS_NEXT: begin
                    r_divbusy <= 1'b0;
                    if (r_job.kind == rau_pkg::JK_EQ && !r_second && cur_num_zero)
                        r_second <= 1'b1;
                end
                rau_pkg::BS_GCD: begin
                    if (!r_divbusy) begin
                        if (r_y != '0) r_divbusy <= 1'b1;
                    end else if (last) begin
                        r_divbusy <= 1'b0;
                    end
                end
                rau_pkg::BS_DIVN: r_divbusy <= !(r_divbusy && last);
                rau_pkg::BS_DIVD: begin
                    r_divbusy <= !(r_divbusy && last);
                    if (r_divbusy && last && r_job.kind == rau_pkg::JK_EQ)
                        r_second <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_st == rau_pkg::BS_IDLE && !i_empty) r_job <= i_job;
        unique case (r_st)
            rau_pkg::BS_NEXT: begin
                if (r_second) begin
                    r_x <= r_job.num_b; r_y <= r_job.den_b;
                end else begin
                    r_x <= r_job.num_a; r_y <= r_job.den_a;
                end
                // a zero numerator is never negative
                r_neg <= cur_num_zero ? 1'b0 : (r_second ? r_job.neg_b : r_job.neg_a);
                if (cur_num_zero) begin
                    r_qn <= '0; r_qd <= M'(1);
                    if (!r_second) begin
                        r_ran <= '0; r_rad <= M'(1); r_rneg <= 1'b0;
                    end
                end
            end
            rau_pkg::BS_GCD: begin
                if (!r_divbusy) begin
                    if (r_y == '0) begin
                        r_g <= r_x;
                    end else begin
                        r_rem <= '0; r_dvd <= r_x; r_bit <= C'(M - 1);
                    end
                end else begin
                    r_rem <= trial[M] ? rsh : trial[M-1:0];
                    r_dvd <= {r_dvd[M-2:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (last) begin
                        r_x <= r_y;
                        r_y <= trial[M] ? rsh : trial[M-1:0];
                    end
                end
            end
            rau_pkg::BS_DIVN, rau_pkg::BS_DIVD: begin
                if (!r_divbusy) begin
                    r_rem <= '0; r_quo <= '0; r_bit <= C'(M - 1);
                    r_dvd <= (r_st == rau_pkg::BS_DIVN)
                             ? (r_second ? r_job.num_b : r_job.num_a)
                             : (r_second ? r_job.den_b : r_job.den_a);
                end else begin
                    r_rem <= trial[M] ? rsh : trial[M-1:0];
                    r_dvd <= {r_dvd[M-2:0], 1'b0};
                    r_quo <= {r_quo[M-2:0], !trial[M]};
                    r_bit <= r_bit - 1'b1;
                    if (last) begin
                        if (r_st == rau_pkg::BS_DIVN) r_qn <= {r_quo[M-2:0], !trial[M]};
                        else begin
                            r_qd <= {r_quo[M-2:0], !trial[M]};
                            if (!r_second) begin
                                r_ran <= r_qn; r_rad <= {r_quo[M-2:0], !trial[M]};
                                r_rneg <= r_neg;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    logic [M:0] sn;
    always_comb begin
        sn = r_neg ? -({1'b0, r_qn}) : {1'b0, r_qn};
        o_valid    = (r_st == rau_pkg::BS_OUT);
        o_res_num  = '0;
        o_res_den  = '0;
        o_is_equal = 1'b0;
        o_status   = r_job.status;
        unique case (r_job.kind)
            rau_pkg::JK_ARITH: begin
                o_res_num = sn[rau_pkg::NumBits-1:0];
                o_res_den = r_qd[rau_pkg::DenBits-1:0];
            end
            rau_pkg::JK_EQ: o_is_equal = (r_ran == r_qn) && (r_rad == r_qd) && (r_rneg == r_neg);
            default: ;
        endcase
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");
    property p_out_fixed;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rau_pkg::ST_OK) |-> (o_res_den == '0);
    endproperty
    a_out_fixed: assert property (p_out_fixed) else $error("error result not zero");
    property p_pop_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_st == rau_pkg::BS_IDLE) && !i_empty;
    endproperty
    a_pop_idle: assert property (p_pop_idle) else $error("pop outside idle");
    property p_den_nz;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.kind == rau_pkg::JK_ARITH) |-> (r_qd != '0);
    endproperty
    a_den_nz: assert property (p_den_nz) else $error("zero denominator result");
endmodule
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front end, job queue, back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// Takes two signed 16-bit fractions and an operation (add, subtract,
// multiply, divide, equality test) and returns one result word per input
// word: a reduced fraction, an equality flag or an error status. The front
// end registers magnitudes, then forms the cross products and classifies
// error cases into a registered job; jobs wait in a two-entry queue.
// The back end runs the Euclidean GCD on one shared bit-serial restoring
// divider, then divides numerator and denominator by the GCD on the same
// divider. It takes a new job only when idle; the equality test reduces
// both fractions in turn, and error cases and zero numerators skip the
// GCD and the divisions.
// Result words wait in the back end's output state while stalled.
`default_nettype none
module rational_arithmetic_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_req_type,
    input  wire  [15:0] i_a_num,
    input  wire  [15:0] i_a_den,
    input  wire  [15:0] i_b_num,
    input  wire  [15:0] i_b_den,
    output logic        o_valid,
    input  wire         i_stall,
    output logic signed [32:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_status,
    output logic        o_is_equal
);
    logic          job_valid, q_full, q_empty, q_pop;
    rau_pkg::t_job job_in, job_out;

    rau_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_job_valid(job_valid), .i_job_full(q_full), .o_job(job_in)
    );

    rau_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(job_valid), .i_job(job_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_job(job_out)
    );

    rau_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_job(job_out), .o_pop(q_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_status(o_status), .o_is_equal(o_is_equal)
    );
endmodule
`default_nettype wire

FILE: dv/tb_rational_arithmetic_unit.sv
// Testbench for rational_arithmetic_unit: a directed table and random words, checked
// field by field against typed words or an in-bench predictor. Depends on rau_pkg.
`default_nettype none
module tb_rational_arithmetic_unit;

    // Expected result word, one per accepted input word
    typedef struct {
        logic signed [32:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
        logic               is_equal;
    } t_frac_res;

    // Directed row; chk set when the expected word is typed in
    typedef struct {
        logic [2:0]  op;
        logic [15:0] an, ad, bn, bd;
        bit          chk;
        t_frac_res   res;
    } t_row;

    logic        clk, rst_n;
    logic        in_valid;
    logic        o_stall_w, o_valid_w;
    logic        out_stall;
    logic [2:0]  req_type;
    logic [15:0] a_num, a_den, b_num, b_den;
    logic signed [32:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
    logic        is_equal;

    t_frac_res   pending_q[$];
    int          errors = 0;
    int          words_out = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 0;
    localparam int CycleLimit = 4000000;

    rational_arithmetic_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(o_stall_w),
        .i_req_type(req_type), .i_a_num(a_num), .i_a_den(a_den),
        .i_b_num(b_num), .i_b_den(b_den),
        .o_valid(o_valid_w), .i_stall(out_stall),
        .o_res_num(res_num), .o_res_den(res_den),
        .o_status(status), .o_is_equal(is_equal)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Cycle counter doubles as the watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce signed num/den (den nonzero); returns sign-carrying num, positive den
    function automatic void reduce_frac(input longint n, input longint d,
                                        output longint rn, output longint unsigned rd);
        longint unsigned mn, md, g;
        bit neg;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        if (mn == 0) begin
            rn = 0;
            rd = 1;
            return;
        end
        neg = (n < 0) != (d < 0);
        g = euclid(mn, md);
        rn = neg ? -longint'(mn / g) : longint'(mn / g);
        rd = md / g;
    endfunction

    function automatic t_frac_res predict_frac(logic [2:0] op, logic [15:0] an_r,
            logic [15:0] ad_r, logic [15:0] bn_r, logic [15:0] bd_r);
        t_frac_res r;
        longint an, ad, bn, bd, n, d, rn, rn2;
        longint unsigned rd, rd2;
        r = '{num: '0, den: '0, status: rau_pkg::ST_OK, is_equal: 1'b0};
        an = longint'($signed(an_r));
        ad = longint'($signed(ad_r));
        bn = longint'($signed(bn_r));
        bd = longint'($signed(bd_r));
        if (op > rau_pkg::OP_EQ) return r;
        if (ad == 0 || bd == 0) begin
            r.status = rau_pkg::ST_ZERODEN;
            return r;
        end
        case (op)
            rau_pkg::OP_EQ: begin
                reduce_frac(an, ad, rn, rd);
                reduce_frac(bn, bd, rn2, rd2);
                r.is_equal = (rn == rn2) && (rd == rd2);
                return r;
            end
            rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            rau_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            rau_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
            default: begin
                if (bn == 0) begin
                    r.status = rau_pkg::ST_DIV0;
                    return r;
                end
                n = an * bd;
                d = ad * bn;
            end
        endcase
        reduce_frac(n, d, rn, rd);
        r.num = rn[32:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // Output side: stall at random, or hold off wholesale when asked
    always @(negedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Result checking at the rising edge
    always @(posedge clk) begin
        t_frac_res e;
        if (rst_n && o_valid_w && !out_stall) begin
            words_out <= words_out + 1;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                errors = errors + 1;
            end else begin
                e = pending_q.pop_front();
                if (res_num !== e.num) begin
                    $error("res_num exp %0d got %0d", e.num, res_num); errors = errors + 1;
                end
                if (res_den !== e.den) begin
                    $error("res_den exp %0d got %0d", e.den, res_den); errors = errors + 1;
                end
                if (status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, status); errors = errors + 1;
                end
                if (is_equal !== e.is_equal) begin
                    $error("is_equal exp %0d got %0d", e.is_equal, is_equal);
                    errors = errors + 1;
                end
            end
        end
    end

    // Offer one word; holds until accepted. Valid stays up afterwards so that
    // words can follow back to back; drain() drops it.
    task automatic send_word(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
                             logic [15:0] bn, logic [15:0] bd, t_frac_res exp_res);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
        @(posedge clk);
        while (o_stall_w) @(posedge clk);
        pending_q.push_back(exp_res);
        @(negedge clk);
    endtask

    // Random operand: mostly small values so Euclid stays short, some full range
    function automatic logic [15:0] rand_opnd();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'(0);
            default: return 16'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic send_random(int n);
        logic [2:0] op;
        logic [15:0] an, ad, bn, bd;
        repeat (n) begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            an = rand_opnd(); ad = rand_opnd(); bn = rand_opnd(); bd = rand_opnd();
            if (ad == 0 && $urandom_range(3) != 0) ad = 16'd1;
            if (bd == 0 && $urandom_range(3) != 0) bd = 16'hffff;
            if (op == rau_pkg::OP_EQ && $urandom_range(1)) begin
                // scaled copy so equal outcomes are common
                an = 16'($signed($urandom_range(60)) - 30);
                ad = 16'($urandom_range(60, 1));
                bn = an * 16'd3; bd = ad * 16'd3;
            end
            send_word(op, an, ad, bn, bd, predict_frac(op, an, ad, bn, bd));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
    endtask

    t_row rows[$];

    initial begin
        t_frac_res e;
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
        req_type = '0; a_num = '0; a_den = '0; b_num = '0; b_den = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: zero denominators, divide by zero, unused codes, extremes, every op
        rows.push_back('{rau_pkg::OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1,
                         '{0, 0, rau_pkg::ST_ZERODEN, 0}});
        rows.push_back('{rau_pkg::OP_DIV, 16'd1, 16'd1, 16'd0, 16'd0, 1,
                         '{0, 0, rau_pkg::ST_ZERODEN, 0}});
        rows.push_back('{rau_pkg::OP_EQ, 16'd1, 16'd2, 16'd1, 16'd0, 1,
                         '{0, 0, rau_pkg::ST_ZERODEN, 0}});
        rows.push_back('{rau_pkg::OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5, 1,
                         '{0, 0, rau_pkg::ST_DIV0, 0}});
        rows.push_back('{3'd5, 16'd3, 16'd4, 16'd1, 16'd5, 1, '{0, 0, rau_pkg::ST_OK, 0}});
        rows.push_back('{3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1,
                         '{0, 0, rau_pkg::ST_OK, 0}});
        rows.push_back('{rau_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd2, 1,
                         '{1, 1, rau_pkg::ST_OK, 0}});
        rows.push_back('{rau_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1,
                         '{0, 1, rau_pkg::ST_OK, 0}});
        rows.push_back('{rau_pkg::OP_MUL, 16'd0, 16'hffff, 16'd7, 16'd3, 1,
                         '{0, 1, rau_pkg::ST_OK, 0}});
        rows.push_back('{rau_pkg::OP_EQ, 16'd1, 16'd2, 16'd2, 16'd4, 1,
                         '{0, 0, rau_pkg::ST_OK, 1}});
        rows.push_back('{rau_pkg::OP_EQ, 16'd1, 16'd2, 16'hffff, 16'hfffe, 1,
                         '{0, 0, rau_pkg::ST_OK, 1}});
        rows.push_back('{rau_pkg::OP_EQ, 16'd1, 16'd2, 16'd1, 16'd3, 1,
                         '{0, 0, rau_pkg::ST_OK, 0}});
        rows.push_back('{rau_pkg::OP_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1, 0, '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_SUB, 16'h8000, 16'd1, 16'h7fff, 16'd1, 0, '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7ffe, 0,
                         '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'd1, 0,
                         '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 0, '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0,
                         '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_DIV, 16'd5, 16'hfff9, 16'hfffd, 16'd11, 0, '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_SUB, 16'h7fff, 16'h7ffe, 16'h7ffd, 16'h7ffc, 0,
                         '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_EQ, 16'h8000, 16'h8000, 16'd1, 16'd1, 0, '{0, 0, 0, 0}});
        rows.push_back('{rau_pkg::OP_EQ, 16'd0, 16'd5, 16'd0, 16'h8000, 0, '{0, 0, 0, 0}});
        foreach (rows[i]) begin
            e = rows[i].chk ? rows[i].res
                : predict_frac(rows[i].op, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd);
            send_word(rows[i].op, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd, e);
        end
        drain();

        // Random phases: free running, sender idle, receiver stalling, both
        send_random(100);
        send_idle_pct = 73; send_random(90);
        send_idle_pct = 0; recv_stall_pct = 73; send_random(90);
        send_idle_pct = 17; recv_stall_pct = 17; send_random(90);

        // Long receiver hold-off while the sender keeps offering words
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            send_random(30);
        join
        send_random(50);
        drain();

        $display("Covered %0d result words over all five operations, error and unused codes,",
                 words_out);
        $display("operand extremes, several idle/stall mixes and a long output hold-off.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
